// File: hdl/mrf_pkg.sv
// Package for the message rule filter: item token, operator and request codes,
// and the single-rule compare function shared by the cell chain.
// No dependencies.
package mrf_pkg;

    localparam int NUM_FIELDS = 3;
    localparam int VAL_W      = 32;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_CHECK = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        OP_NEVER = 3'd0,
        OP_EQ    = 3'd1,
        OP_NE    = 3'd2,
        OP_GE    = 3'd3,
        OP_GT    = 3'd4,
        OP_LE    = 3'd5,
        OP_LT    = 3'd6,
        OP_RANGE = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADSEL = 2'd2
    } t_status;

    // what an item does as it walks the chain
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_CHECK = 2'd3
    } t_cmd;

    typedef struct packed {
        logic                                vld;
        t_cmd                                cmd;
        logic [1:0]                          fsel;
        t_op                                 op;
        logic [VAL_W-1:0]                    va;
        logic [VAL_W-1:0]                    vb;
        logic [NUM_FIELDS-1:0][VAL_W-1:0]    key;
        t_status                             status;
        logic [NUM_FIELDS-1:0]               any_vld;
        logic [NUM_FIELDS-1:0]               any_hit;
    } t_token;

    function automatic logic rule_hit(input t_op op, input logic [VAL_W-1:0] lo,
                                      input logic [VAL_W-1:0] hi,
                                      input logic [VAL_W-1:0] x);
        logic r;
        case (op)
            OP_EQ:    r = (x == lo);
            OP_NE:    r = (x != lo);
            OP_GE:    r = (x >= lo);
            OP_GT:    r = (x > lo);
            OP_LE:    r = (x <= lo);
            OP_LT:    r = (x < lo);
            OP_RANGE: r = (x >= lo) && (x <= hi);
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/mrf_cell.sv
// One cell of the rule chain: holds rule slot CELL_IDX of all three field lists,
// scores passing check items against it and forwards every item to the next cell.
// Depends on mrf_pkg.
module mrf_cell import mrf_pkg::*; #(
    parameter int SLOT_W   = 3,
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_token            i_tok,
    input  logic [SLOT_W-1:0] i_slot,
    output t_token            o_tok,
    output logic [SLOT_W-1:0] o_slot
);

    t_op                   r_kind [NUM_FIELDS];
    logic [VAL_W-1:0]      r_low  [NUM_FIELDS];
    logic [VAL_W-1:0]      r_high [NUM_FIELDS];
    logic [NUM_FIELDS-1:0] r_vld, n_vld;
    logic [NUM_FIELDS-1:0] w_wr;
    logic                  r_tok_vld;
    t_token                r_tok, n_tok;
    logic [SLOT_W-1:0]     r_slot;

    always_comb begin
        n_tok = i_tok;
        for (int f = 0; f < NUM_FIELDS; f++) begin
            if (i_tok.cmd == CMD_CHECK) begin
                n_tok.any_vld[f] = i_tok.any_vld[f] | r_vld[f];
                n_tok.any_hit[f] = i_tok.any_hit[f] |
                    (r_vld[f] & rule_hit(r_kind[f], r_low[f], r_high[f], i_tok.key[f]));
            end
        end
    end

    always_comb begin
        n_vld = r_vld;
        w_wr  = '0;
        if (i_en && i_tok.vld) begin
            if (i_tok.cmd == CMD_CLEAR) begin
                n_vld = '0;
            end else if (i_tok.cmd == CMD_WRITE && i_slot == SLOT_W'(CELL_IDX)) begin
                for (int f = 0; f < NUM_FIELDS; f++) begin
                    if (i_tok.fsel == 2'(f)) begin
                        w_wr[f]  = 1'b1;
                        n_vld[f] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_tok_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_en) begin
                r_tok_vld <= i_tok.vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int f = 0; f < NUM_FIELDS; f++) begin
            if (w_wr[f]) begin
                r_kind[f] <= i_tok.op;
                r_low[f]  <= i_tok.va;
                r_high[f] <= i_tok.vb;
            end
        end
        if (i_en) begin
            r_tok  <= n_tok;
            r_slot <= i_slot;
        end
    end

    always_comb begin
        o_tok     = r_tok;
        o_tok.vld = r_tok_vld;
    end
    assign o_slot = r_slot;

endmodule

// File: hdl/message_rule_filter_unit.sv
// Top level of the message rule filter: stream ports, list fill counts, the cell chain
// and the result register.
// Depends on mrf_pkg and mrf_cell.

// Message filter over size, tag and communicator id, each with a list of up to
// RULES_PER_FIELD rules. Every item (clear, add rule, check message) gives one result.
// Items walk a chain of RULES_PER_FIELD cells, one cell per cycle, each cell holding one
// rule slot of every list; while the chain is not held the block takes one item per cycle,
// and each result passes through the cell registers and then the result register.
// When the result is not taken the whole chain holds. Add status is decided
// at intake from the fill counts, so a full list or bad field select is reported on the
// add's own result.
module message_rule_filter_unit import mrf_pkg::*; #(
    parameter int RULES_PER_FIELD = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // field_sel[1:0], new_rule_op[4:2], value_a[36:5], value_b[68:37],
    // msg_size[100:69], msg_tag[132:101], msg_comm[164:133], zero pad [167:165]
    input  logic [167:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // matches_res[0], status[2:1], zero pad [7:3]
    output logic [7:0]   m_axis_tdata
);

    localparam int CNT_W  = $clog2(RULES_PER_FIELD + 1);
    localparam int SLOT_W = (RULES_PER_FIELD > 1) ? $clog2(RULES_PER_FIELD) : 1;

    logic              w_en;
    logic              w_acc;
    t_req              w_req;
    t_token            w_tok  [RULES_PER_FIELD+1];
    logic [SLOT_W-1:0] w_slot [RULES_PER_FIELD+1];
    logic [CNT_W-1:0]  r_count [NUM_FIELDS];
    logic [CNT_W-1:0]  n_count [NUM_FIELDS];
    t_token            n_entry;
    logic [SLOT_W-1:0] n_entry_slot;
    logic              r_out_valid;
    logic              r_out_match;
    t_status           r_out_status;
    t_token            w_last;
    logic              w_pass;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_req         = t_req'(s_axis_tuser);

    // intake: decode request, settle add status and slot from the fill counts
    always_comb begin
        n_entry         = '0;
        n_entry.vld     = w_acc;
        n_entry.fsel    = s_axis_tdata[1:0];
        n_entry.op      = t_op'(s_axis_tdata[4:2]);
        n_entry.va      = s_axis_tdata[36:5];
        n_entry.vb      = s_axis_tdata[68:37];
        n_entry.key[0]  = s_axis_tdata[100:69];
        n_entry.key[1]  = s_axis_tdata[132:101];
        n_entry.key[2]  = s_axis_tdata[164:133];
        n_entry.cmd     = CMD_NONE;
        n_entry.status  = ST_OK;
        n_entry_slot    = '0;
        for (int f = 0; f < NUM_FIELDS; f++) begin
            n_count[f] = r_count[f];
        end
        if (w_acc) begin
            case (w_req)
                REQ_CLEAR: begin
                    n_entry.cmd = CMD_CLEAR;
                    for (int f = 0; f < NUM_FIELDS; f++) begin
                        n_count[f] = '0;
                    end
                end
                REQ_ADD: begin
                    if (s_axis_tdata[1:0] >= 2'(NUM_FIELDS)) begin
                        n_entry.status = ST_BADSEL;
                    end else if (r_count[s_axis_tdata[1:0]] == CNT_W'(RULES_PER_FIELD)) begin
                        n_entry.status = ST_FULL;
                    end else begin
                        n_entry.cmd  = CMD_WRITE;
                        n_entry_slot = r_count[s_axis_tdata[1:0]][SLOT_W-1:0];
                        n_count[s_axis_tdata[1:0]] = r_count[s_axis_tdata[1:0]] + 1'b1;
                    end
                end
                REQ_CHECK: begin
                    n_entry.cmd = CMD_CHECK;
                end
                default: begin
                    n_entry.cmd = CMD_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < NUM_FIELDS; f++) begin
                r_count[f] <= '0;
            end
        end else begin
            for (int f = 0; f < NUM_FIELDS; f++) begin
                r_count[f] <= n_count[f];
            end
        end
    end

    assign w_tok[0]  = n_entry;
    assign w_slot[0] = n_entry_slot;

    for (genvar i = 0; i < RULES_PER_FIELD; i++) begin : g_cell
        mrf_cell #(
            .SLOT_W   (SLOT_W),
            .CELL_IDX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tok   (w_tok[i]),
            .i_slot  (w_slot[i]),
            .o_tok   (w_tok[i+1]),
            .o_slot  (w_slot[i+1])
        );
    end

    assign w_last = w_tok[RULES_PER_FIELD];
    // a field passes when its list is empty or some rule hit
    assign w_pass = &(~w_last.any_vld | w_last.any_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_last.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_last.vld) begin
            r_out_match  <= (w_last.cmd == CMD_CHECK) && w_pass;
            r_out_status <= w_last.status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_status, r_out_match};

    for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_chk
        a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_count[f] <= CNT_W'(RULES_PER_FIELD))
            else $error("fill count above list size");

        a_count_incr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (w_acc && n_entry.cmd == CMD_WRITE && n_entry.fsel == 2'(f))
                |=> r_count[f] == CNT_W'($past(r_count[f]) + 1'b1))
            else $error("accepted rule add did not bump fill count");
    end

    a_clear_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_req == REQ_CLEAR)
            |=> (r_count[0] == '0 && r_count[1] == '0 && r_count[2] == '0))
        else $error("clear left a nonempty fill count");

    a_match_only_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2:1] != ST_OK) |-> !m_axis_tdata[0])
        else $error("match flagged on a dropped rule add");

endmodule
